FILE: rtl/core/ascii_command_line_parser_assert.svh
// Assertion macros used by the command line parser checker.
`ifndef ASCII_COMMAND_LINE_PARSER_ASSERT_SVH
`define ASCII_COMMAND_LINE_PARSER_ASSERT_SVH

// A condition that must always hold out of reset.
`define ACLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A cause that must be followed by a consequence in the same cycle.
`define ACLP_ASSERT_IMPLY(lbl, cause, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (cons)) \
    else $error(msg);

// A stalled valid must still be high in the next cycle.
`define ACLP_ASSERT_HOLD(lbl, vld, rdy, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy)) |=> (vld)) \
    else $error(msg);

`endif

FILE: rtl/core/aclp_pkg.sv
// Shared types and constants of the command line parser.
`timescale 1ns / 1ps
package aclp_pkg;

  localparam int LINE_LEN_DEF   = 32;
  localparam int MAX_PARAMS_DEF = 8;
  localparam int CMD_CHARS_DEF  = 8;

  // Parameter counts up to sixteen fit in this width.
  localparam int TOTAL_W = 5;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // One finished line as handed from the parser to the result stage.
  typedef struct packed {
    logic               ok;
    logic [63:0]        text;
    logic [4:0]         len;
    logic [TOTAL_W-1:0] total;
  } hdr_t;

endpackage

FILE: rtl/core/aclp_fifo.sv
// Small register FIFO used between the parser and the result stage.
`timescale 1ns / 1ps
module aclp_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [IDX_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == IDX_LAST) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == IDX_LAST) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

FILE: rtl/core/aclp_front.sv
// Byte parser: tracks the command word and parameters of the current line.
`timescale 1ns / 1ps
module aclp_front #(
  parameter int LINE_LEN   = aclp_pkg::LINE_LEN_DEF,
  parameter int MAX_PARAMS = aclp_pkg::MAX_PARAMS_DEF,
  parameter int CMD_CHARS  = aclp_pkg::CMD_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output logic                par_push,
  output logic [31:0]         par_value,
  output logic                hdr_push,
  output aclp_pkg::hdr_t      hdr
);

  localparam int POS_W = $clog2(LINE_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LEN - 1);
  localparam logic [aclp_pkg::TOTAL_W-1:0] TOTAL_MAX = aclp_pkg::TOTAL_W'(MAX_PARAMS);

  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_PARAM = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;
  localparam logic [1:0] PH_BAD   = 2'd3;

  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic [63:0]                   letters_r, letters_nxt;
  logic [4:0]                    len_r, len_nxt;
  logic [31:0]                   acc_r, acc_nxt;
  logic                          neg_r, neg_nxt;
  logic                          started_r, started_nxt;
  logic [aclp_pkg::TOTAL_W-1:0]  total_r, total_nxt;

  logic [7:0] low;
  logic       blank, is_digit, is_letter;

  assign low       = rx_byte | aclp_pkg::CASE_BIT;
  assign blank     = (rx_byte == aclp_pkg::CH_SP) || (rx_byte == aclp_pkg::CH_TAB);
  assign is_digit  = (rx_byte >= aclp_pkg::CH_ZERO) && (rx_byte <= aclp_pkg::CH_NINE);
  assign is_letter = (low >= aclp_pkg::CH_LOW_A) && (low <= aclp_pkg::CH_LOW_Z);

  always_comb begin
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    letters_nxt = letters_r;
    len_nxt     = len_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    total_nxt   = total_r;
    par_push    = 1'b0;
    par_value   = neg_r ? (32'd0 - acc_r) : acc_r;
    hdr_push    = 1'b0;
    hdr         = '0;

    if (take) begin
      if (pos_r != POS_LAST) begin
        pos_nxt = pos_r + 1'b1;
        unique case (phase_r)
          PH_CMD: begin
            priority if (len_r == '0 && blank) begin
              // Leading blanks before the command word are skipped.
            end else if (rx_byte == aclp_pkg::CH_SP || rx_byte == aclp_pkg::CH_COMMA ||
                         rx_byte == aclp_pkg::CH_CR) begin
              if (len_r == '0) begin
                phase_nxt = PH_BAD;
              end else begin
                phase_nxt = (rx_byte == aclp_pkg::CH_SP) ? PH_PARAM : PH_STOP;
              end
            end else if (is_letter) begin
              for (int k = 0; k < CMD_CHARS; k++) begin
                if (len_r == 5'(k)) begin
                  letters_nxt[k*8 +: 8] = low;
                end
              end
              if (len_r != 5'd31) begin
                len_nxt = len_r + 1'b1;
              end
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          PH_PARAM: begin
            priority if (!started_r && blank) begin
              // Blanks before a parameter are skipped.
            end else if (!started_r && rx_byte == aclp_pkg::CH_MINUS) begin
              neg_nxt     = 1'b1;
              started_nxt = 1'b1;
            end else if (is_digit) begin
              // Multiply by ten as two shifts and an add, wrapping at 32 bits.
              acc_nxt     = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} +
                            {28'd0, rx_byte[3:0]};
              started_nxt = 1'b1;
            end else if ((rx_byte == aclp_pkg::CH_COMMA || rx_byte == aclp_pkg::CH_CR) &&
                         started_r) begin
              par_push    = 1'b1;
              total_nxt   = total_r + 1'b1;
              acc_nxt     = '0;
              neg_nxt     = 1'b0;
              started_nxt = 1'b0;
              if (total_r + 1'b1 >= TOTAL_MAX) begin
                phase_nxt = PH_STOP;
              end
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_STOP: begin
          end
          PH_BAD: begin
          end
        endcase
      end

      if (rx_byte == aclp_pkg::CH_CR) begin
        hdr_push = 1'b1;
        if (phase_nxt == PH_PARAM || phase_nxt == PH_STOP) begin
          hdr.ok    = 1'b1;
          hdr.text  = letters_nxt;
          hdr.len   = len_nxt;
          hdr.total = total_nxt;
        end
        pos_nxt     = '0;
        phase_nxt   = PH_CMD;
        letters_nxt = '0;
        len_nxt     = '0;
        acc_nxt     = '0;
        neg_nxt     = 1'b0;
        started_nxt = 1'b0;
        total_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= PH_CMD;
      letters_r <= '0;
      len_r     <= '0;
      acc_r     <= '0;
      neg_r     <= 1'b0;
      started_r <= 1'b0;
      total_r   <= '0;
    end else begin
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      letters_r <= letters_nxt;
      len_r     <= len_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      started_r <= started_nxt;
      total_r   <= total_nxt;
    end
  end

endmodule

FILE: rtl/core/aclp_back.sv
// Result stage: one result per unstalled cycle from queued lines and parameters.
`timescale 1ns / 1ps
module aclp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  aclp_pkg::hdr_t      hdr,
  input  logic                hdr_empty,
  output logic                hdr_pop,
  input  logic [31:0]         par_value,
  input  logic                par_empty,
  output logic                par_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_line_ok,
  output logic [63:0]         out_cmd_text,
  output logic [4:0]          out_cmd_len,
  output logic [3:0]          out_param_count,
  output logic                out_has_param,
  output logic [2:0]          out_param_index,
  output logic signed [31:0]  out_param_value,
  output logic                out_last
);

  localparam int TW = aclp_pkg::TOTAL_W;

  logic          valid_r, valid_nxt;
  logic          ok_r, ok_nxt;
  logic [63:0]   text_r, text_nxt;
  logic [4:0]    len_r, len_nxt;
  logic [TW-1:0] count_r, count_nxt;
  logic          has_r, has_nxt;
  logic [TW-1:0] idx_r, idx_nxt;
  logic [31:0]   value_r, value_nxt;
  logic          last_r, last_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic          load;

  // The output register refills whenever it is empty or its result transfers.
  assign load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    ok_nxt    = ok_r;
    text_nxt  = text_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    has_nxt   = has_r;
    idx_nxt   = idx_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    rem_nxt   = rem_r;
    hdr_pop   = 1'b0;
    par_pop   = 1'b0;

    if (load) begin
      priority if (rem_r != '0) begin
        // Parameters are queued no later than their header, so are present.
        valid_nxt = !par_empty;
        if (!par_empty) begin
          par_pop   = 1'b1;
          has_nxt   = 1'b1;
          idx_nxt   = has_r ? idx_r + 1'b1 : '0;
          value_nxt = par_value;
          last_nxt  = (rem_r == TW'(1));
          rem_nxt   = rem_r - 1'b1;
        end
      end else if (!hdr_empty) begin
        hdr_pop   = 1'b1;
        valid_nxt = 1'b1;
        ok_nxt    = hdr.ok;
        text_nxt  = hdr.text;
        len_nxt   = hdr.len;
        count_nxt = hdr.total;
        has_nxt   = 1'b0;
        idx_nxt   = '0;
        value_nxt = '0;
        last_nxt  = (hdr.total == '0);
        rem_nxt   = hdr.total;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= '0;
      has_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rem_r   <= rem_nxt;
      has_r   <= has_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    text_r  <= text_nxt;
    len_r   <= len_nxt;
    count_r <= count_nxt;
    idx_r   <= idx_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_line_ok     = ok_r;
  assign out_cmd_text    = text_r;
  assign out_cmd_len     = len_r;
  assign out_param_count = count_r[3:0];
  assign out_has_param   = has_r;
  assign out_param_index = idx_r[2:0];
  assign out_param_value = value_r;
  assign out_last        = last_r;

endmodule

FILE: rtl/core/ascii_command_line_parser.sv
// Top level of the ASCII command line parser.
// The parser takes one received byte per cycle: a byte is accepted whenever both
// internal queues have room, and its parsing (letter folding, a multiply by ten
// and add for digits) finishes in that cycle. On a carriage return the parsed
// line is queued; the result stage then emits the header and each parameter,
// one result per cycle while out_ready is high, so a parsed line with N
// parameters gives N+1 results. Parameters are queued as they complete (queue
// depth 2*MAX_PARAMS) and headers in a two-entry queue; the byte input stalls
// only when one of them is full. The first LINE_LEN-1 bytes of a line are
// parsed, later ones are ignored until the carriage return. A failed line
// gives a single result with last set and all other fields zero.
`timescale 1ns / 1ps
module ascii_command_line_parser #(
  parameter int LINE_LEN   = aclp_pkg::LINE_LEN_DEF,
  parameter int MAX_PARAMS = aclp_pkg::MAX_PARAMS_DEF,
  parameter int CMD_CHARS  = aclp_pkg::CMD_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_line_ok,
  output logic [63:0]        out_cmd_text,
  output logic [4:0]         out_cmd_len,
  output logic [3:0]         out_param_count,
  output logic               out_has_param,
  output logic [2:0]         out_param_index,
  output logic signed [31:0] out_param_value,
  output logic               out_last
);

  localparam int HDR_W = $bits(aclp_pkg::hdr_t);

  logic           take;
  logic           par_push, par_pop, par_full, par_empty;
  logic [31:0]    par_din, par_dout;
  logic           hdr_push, hdr_pop, hdr_full, hdr_empty;
  aclp_pkg::hdr_t hdr_din, hdr_dout;
  logic [HDR_W-1:0] hdr_raw;

  assign in_ready = !par_full && !hdr_full;
  assign take     = in_valid && in_ready;
  assign hdr_dout = aclp_pkg::hdr_t'(hdr_raw);

  aclp_front #(
    .LINE_LEN   (LINE_LEN),
    .MAX_PARAMS (MAX_PARAMS),
    .CMD_CHARS  (CMD_CHARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .par_push  (par_push),
    .par_value (par_din),
    .hdr_push  (hdr_push),
    .hdr       (hdr_din)
  );

  aclp_fifo #(
    .WIDTH (32),
    .DEPTH (2 * MAX_PARAMS)
  ) u_par_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (par_push),
    .din   (par_din),
    .pop   (par_pop),
    .dout  (par_dout),
    .full  (par_full),
    .empty (par_empty)
  );

  aclp_fifo #(
    .WIDTH (HDR_W),
    .DEPTH (2)
  ) u_hdr_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (hdr_push),
    .din   (HDR_W'(hdr_din)),
    .pop   (hdr_pop),
    .dout  (hdr_raw),
    .full  (hdr_full),
    .empty (hdr_empty)
  );

  aclp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hdr             (hdr_dout),
    .hdr_empty       (hdr_empty),
    .hdr_pop         (hdr_pop),
    .par_value       (par_dout),
    .par_empty       (par_empty),
    .par_pop         (par_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_ok     (out_line_ok),
    .out_cmd_text    (out_cmd_text),
    .out_cmd_len     (out_cmd_len),
    .out_param_count (out_param_count),
    .out_has_param   (out_has_param),
    .out_param_index (out_param_index),
    .out_param_value (out_param_value),
    .out_last        (out_last)
  );

endmodule

FILE: rtl/core/aclp_checker.sv
// Port checker for the command line parser, bound to the top level.
`timescale 1ns / 1ps
`include "ascii_command_line_parser_assert.svh"
module aclp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_line_ok,
  input logic [4:0]         out_cmd_len,
  input logic [3:0]         out_param_count,
  input logic               out_has_param,
  input logic [2:0]         out_param_index,
  input logic signed [31:0] out_param_value,
  input logic               out_last
);

  `ACLP_ASSERT_HOLD(a_out_hold, out_valid, out_ready, "result withdrawn before transfer")
  `ACLP_ASSERT_IMPLY(a_fail_single, out_valid && !out_line_ok, out_last && !out_has_param && out_cmd_len == 5'd0, "failed line result malformed")
  `ACLP_ASSERT_IMPLY(a_param_ok, out_valid && out_has_param, out_line_ok && out_param_count != 4'd0, "parameter on a line without parameters")
  `ACLP_ASSERT_IMPLY(a_hdr_zero, out_valid && !out_has_param, out_param_index == 3'd0 && out_param_value == 32'sd0, "header carries parameter data")

endmodule

bind ascii_command_line_parser aclp_checker u_aclp_checker (.*);

FILE: bench/ascii_command_line_parser_test.sv
// Self-checking testbench for the ASCII command line parser.
`timescale 1ns / 1ps
module ascii_command_line_parser_test;

  localparam int LINE_LEN       = aclp_pkg::LINE_LEN_DEF;
  localparam int MAX_PARAMS     = aclp_pkg::MAX_PARAMS_DEF;
  localparam int CMD_CHARS      = aclp_pkg::CMD_CHARS_DEF;
  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [7:0] CH_CR    = aclp_pkg::CH_CR;
  localparam logic [7:0] CH_SP    = aclp_pkg::CH_SP;
  localparam logic [7:0] CH_TAB   = aclp_pkg::CH_TAB;
  localparam logic [7:0] CH_COMMA = aclp_pkg::CH_COMMA;
  localparam logic [7:0] CH_MINUS = aclp_pkg::CH_MINUS;
  localparam logic [7:0] CH_LOW_A = aclp_pkg::CH_LOW_A;
  localparam logic [7:0] CH_LOW_Z = aclp_pkg::CH_LOW_Z;
  localparam logic [7:0] CH_ZERO  = aclp_pkg::CH_ZERO;
  localparam logic [7:0] CH_NINE  = aclp_pkg::CH_NINE;
  localparam logic [7:0] CASE_BIT = aclp_pkg::CASE_BIT;

  typedef enum logic [1:0] {ST_WORD, ST_PARAMS, ST_DONE, ST_REJECT} parse_state_t;

  typedef struct packed {
    logic               ok;
    logic [63:0]        text;
    logic [4:0]         len;
    logic [3:0]         count;
    logic               has_param;
    logic [2:0]         idx;
    logic signed [31:0] value;
    logic               last;
  } line_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_line_ok;
  logic [63:0]        out_cmd_text;
  logic [4:0]         out_cmd_len;
  logic [3:0]         out_param_count;
  logic               out_has_param;
  logic [2:0]         out_param_index;
  logic signed [31:0] out_param_value;
  logic               out_last;

  // Shadow copy of the line parser state.
  int                 line_pos = 0;
  parse_state_t       pstate = ST_WORD;
  logic [63:0]        word_bits = '0;
  logic [4:0]         word_len = '0;
  logic [31:0]        acc = '0;
  logic               acc_neg = 1'b0;
  logic               in_field = 1'b0;
  logic [31:0]        saved_params [MAX_PARAMS];
  int                 n_params = 0;

  line_result_t       line_results_due [$];
  line_result_t       due;
  logic [7:0]         line_buf [$];

  int send_idle_pct = 27;
  int stall_pct     = 27;
  int hold_left     = 0;
  int bytes_sent    = 0;
  int failures      = 0;
  int quiet_cycles  = 0;

  ascii_command_line_parser #(
    .LINE_LEN  (LINE_LEN),
    .MAX_PARAMS(MAX_PARAMS),
    .CMD_CHARS (CMD_CHARS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_ok    (out_line_ok),
    .out_cmd_text   (out_cmd_text),
    .out_cmd_len    (out_cmd_len),
    .out_param_count(out_param_count),
    .out_has_param  (out_has_param),
    .out_param_index(out_param_index),
    .out_param_value(out_param_value),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Updates the shadow state with one accepted byte and queues the results of a
  // finished line.
  function automatic void parse_rx_byte(input logic [7:0] c);
    logic [7:0]   low;
    logic         blank;
    line_result_t r;
    low   = c | CASE_BIT;
    blank = (c == CH_SP) || (c == CH_TAB);
    if (line_pos < LINE_LEN - 1) begin
      line_pos++;
      case (pstate)
        ST_WORD: begin
          if (word_len != 0 || !blank) begin
            if (c == CH_SP || c == CH_COMMA || c == CH_CR) begin
              if (word_len == 0) pstate = ST_REJECT;
              else pstate = (c == CH_SP) ? ST_PARAMS : ST_DONE;
            end else if (low >= CH_LOW_A && low <= CH_LOW_Z) begin
              if (word_len < CMD_CHARS) word_bits[8*word_len +: 8] = low;
              if (word_len < 31) word_len++;
            end else begin
              pstate = ST_REJECT;
            end
          end
        end
        ST_PARAMS: begin
          if (in_field || !blank) begin
            if (!in_field && c == CH_MINUS) begin
              acc_neg  = 1'b1;
              in_field = 1'b1;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
              acc      = acc * 10 + (c - CH_ZERO);
              in_field = 1'b1;
            end else if ((c == CH_COMMA || c == CH_CR) && in_field) begin
              saved_params[n_params] = acc_neg ? -acc : acc;
              n_params++;
              acc      = '0;
              acc_neg  = 1'b0;
              in_field = 1'b0;
              if (n_params >= MAX_PARAMS) pstate = ST_DONE;
            end else begin
              pstate = ST_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (c != CH_CR) return;

    r = '0;
    if (pstate == ST_WORD || pstate == ST_REJECT) begin
      r.last = 1'b1;
      line_results_due.push_back(r);
    end else begin
      r.ok    = 1'b1;
      r.text  = word_bits;
      r.len   = word_len;
      r.count = n_params[3:0];
      r.last  = (n_params == 0);
      line_results_due.push_back(r);
      for (int i = 0; i < n_params; i++) begin
        r.has_param = 1'b1;
        r.idx       = i[2:0];
        r.value     = saved_params[i];
        r.last      = (i + 1 == n_params);
        line_results_due.push_back(r);
      end
    end
    line_pos  = 0;
    pstate    = ST_WORD;
    word_bits = '0;
    word_len  = '0;
    acc       = '0;
    acc_neg   = 1'b0;
    in_field  = 1'b0;
    n_params  = 0;
  endfunction

  // Called right after a rising edge. Valid stays high across back-to-back
  // transfers and is only lowered when an idle gap is inserted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_CR);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (line_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed lines with random content; the rest is noise or a line
  // with one byte replaced.
  task automatic build_random_line();
    int         roll;
    int         wlen;
    int         delim;
    int         nparams;
    int         ndigits;
    int         pos;
    logic [7:0] ch;
    line_buf.delete();
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 12)) begin
        ch = 8'($urandom_range(0, 255));
        line_buf.push_back(ch);
      end
    end else begin
      repeat ($urandom_range(0, 2)) line_buf.push_back($urandom_range(1) ? CH_SP : CH_TAB);
      wlen = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 9);
      repeat (wlen) begin
        ch = CH_LOW_A + 8'($urandom_range(0, 25));
        if ($urandom_range(1)) ch = ch & ~CASE_BIT;
        line_buf.push_back(ch);
      end
      delim = $urandom_range(9);
      if (delim == 0) begin
        line_buf.push_back(CH_COMMA);
      end else if (delim > 1) begin
        line_buf.push_back(CH_SP);
        nparams = $urandom_range(0, 9);
        for (int p = 0; p < nparams; p++) begin
          if (p > 0) line_buf.push_back(CH_COMMA);
          if ($urandom_range(4) == 0) line_buf.push_back($urandom_range(1) ? CH_SP : CH_TAB);
          if ($urandom_range(2) == 0) line_buf.push_back(CH_MINUS);
          ndigits = ($urandom_range(7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
          repeat (ndigits) begin
            ch = CH_ZERO + 8'($urandom_range(0, 9));
            line_buf.push_back(ch);
          end
        end
      end
      if (roll < 30) begin
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(4))
          0: ch = CH_MINUS;
          1: ch = CH_COMMA;
          2: ch = CH_SP;
          default: ch = 8'($urandom_range(0, 255));
        endcase
        line_buf[pos] = ch;
      end
    end
    line_buf.push_back(CH_CR);
  endtask

  task automatic test_command_words();
    send_text("");
    send_text(" \tcOPy");
    send_text("Go,12");
    send_text("x9 1");
    send_byte("a");
    send_byte(8'h00);
    send_byte(CH_CR);
    send_byte(8'hff);
    send_byte(CH_CR);
    send_text(" ,");
    send_text(" ");
  endtask

  task automatic test_parameter_fields();
    send_text("\tSet 12,-7, 2147483648,-,4");
    send_text("p 1 2");
    send_text("p 5-3");
    send_text("p 7,,8");
    send_text("p 9,");
    send_byte("q");
    send_byte(CH_SP);
    send_byte(8'hff);
    send_byte(CH_CR);
  endtask

  task automatic test_line_limits();
    send_text("m 1,2,3,4,5,6,7,8,9");
    send_text("abcdefghijklmnopqrstuvwxyzabcd");
    send_text("ABCDEFGHIJKLMNOPQRSTUVWXYZABCD 5");
    send_text("abcdefghijklmnopqrstuvwxyzabcde");
    send_text("v 1,23456789012345678901234567890");
    wait_drained();
  endtask

  task automatic test_random_lines(input int target, input int idle, input int stall);
    int first;
    send_idle_pct = idle;
    stall_pct     = stall;
    first         = bytes_sent;
    while (bytes_sent - first < target) begin
      build_random_line();
      send_line();
    end
    wait_drained();
  endtask

  // The receiver holds off while full lines keep arriving, so the parameter
  // queue fills and the byte input has to stall.
  task automatic test_backpressure();
    logic [7:0] ch;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    repeat (4) begin
      line_buf.delete();
      line_buf.push_back("p");
      line_buf.push_back(CH_SP);
      for (int p = 0; p < MAX_PARAMS; p++) begin
        if (p > 0) line_buf.push_back(CH_COMMA);
        ch = CH_ZERO + 8'($urandom_range(0, 9));
        line_buf.push_back(ch);
      end
      line_buf.push_back(CH_CR);
      send_line();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic compare_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (line_results_due.size() == 0) begin
        $error("result transfer with no result outstanding");
        failures++;
      end else begin
        due = line_results_due.pop_front();
        compare_field("line_ok", 64'(due.ok), 64'(out_line_ok));
        compare_field("cmd_text", due.text, out_cmd_text);
        compare_field("cmd_len", 64'(due.len), 64'(out_cmd_len));
        compare_field("param_count", 64'(due.count), 64'(out_param_count));
        compare_field("has_param", 64'(due.has_param), 64'(out_has_param));
        compare_field("param_index", 64'(due.idx), 64'(out_param_index));
        compare_field("param_value", 64'(due.value), 64'(out_param_value));
        compare_field("last", 64'(due.last), 64'(out_last));
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_command_words();
    test_parameter_fields();
    test_line_limits();
    test_random_lines(35, 0, 0);
    test_random_lines(35, 70, 0);
    test_random_lines(35, 0, 70);
    test_random_lines(35, 27, 27);
    test_backpressure();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
